// ===== hdl/pbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_pkg - shared types and constants of the pixel blend block
// Codes for blend modes, layouts and register indexes, the item carried from
// the front end to the arithmetic back end, and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package pbm_pkg;

    // Field and port widths
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 4;
    localparam int MODE_W    = 3;
    localparam int OP_W      = 9;
    localparam int LAYOUT_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;
    localparam int IN_DATA_W  = 2 * NUM_CH * CH_W;
    localparam int OUT_DATA_W = NUM_CH * CH_W;

    // Blend mode codes; PASS is an internal lane code only
    localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SCREEN   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OVERLAY  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DARKEN   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PASS     = 3'd5;

    // Layout codes
    localparam logic [LAYOUT_W-1:0] LAYOUT_GRAY = 2'd0;
    localparam logic [LAYOUT_W-1:0] LAYOUT_RGB  = 2'd1;
    localparam logic [LAYOUT_W-1:0] LAYOUT_RGBA = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPACITY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT     = 2'd2;

    // Register reset values
    localparam logic [MODE_W-1:0]   RST_BLEND_MODE = MODE_NORMAL;
    localparam logic [OP_W-1:0]     RST_OPACITY    = 9'd256;
    localparam logic [LAYOUT_W-1:0] RST_LAYOUT     = LAYOUT_RGB;

    // Arithmetic constants
    localparam logic [OP_W-1:0] OP_ONE     = 9'd256;     // opacity of 1.0
    localparam logic [15:0]     FULL_SQ    = 16'd65025;  // 255 * 255
    localparam logic [23:0]     ROUND_HALF = 24'd32640;  // half of 256 * 255
    localparam logic [15:0]     RECIP_255  = 16'h8081;   // 2^23 / 255, rounded up
    localparam int              RECIP_SH   = 23;
    localparam logic [8:0]      CH_MAX     = 9'd255;

    // Structure depths
    localparam int QUEUE_DEPTH = 4;
    localparam int BACK_STAGES = 6;

    // Per-item classification made by the front end
    typedef struct packed {
        logic [NUM_CH-1:0] keep;        // lane result shown, else zero
        logic [MODE_W-1:0] colour_mode; // lane mode for channels 0..2
        logic [MODE_W-1:0] alpha_mode;  // lane mode for alpha
        logic [OP_W-1:0]   op;          // opacity, saturated to 256
    } t_cls;

    // Item held in the queue between front and back
    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] a;
        logic [NUM_CH-1:0][CH_W-1:0] b;
        t_cls                        cls;
    } t_item;

endpackage

// ===== hdl/pbm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_front - input stage and classification
// Holds the configuration registers, takes pixel transfers, resolves the
// per-lane blend mode, output mask and saturated opacity, and offers the
// classified item to the queue.
// ----------------------------------------------------------------------------
module pbm_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [pbm_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [pbm_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    // pixel input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pbm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // towards the queue
    output logic                            o_push,
    output pbm_pkg::t_item                  o_item,
    input  logic                            i_q_ready
);

    logic [pbm_pkg::MODE_W-1:0]   r_blend_mode;
    logic [pbm_pkg::OP_W-1:0]     r_opacity;
    logic [pbm_pkg::LAYOUT_W-1:0] r_layout;

    logic           r_f_valid;
    pbm_pkg::t_item r_f_item;
    pbm_pkg::t_item n_f_item;
    logic           accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode <= pbm_pkg::RST_BLEND_MODE;
            r_opacity    <= pbm_pkg::RST_OPACITY;
            r_layout     <= pbm_pkg::RST_LAYOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pbm_pkg::CFG_BLEND_MODE: r_blend_mode <= i_cfg_data[pbm_pkg::MODE_W-1:0];
                pbm_pkg::CFG_OPACITY:    r_opacity    <= i_cfg_data[pbm_pkg::OP_W-1:0];
                pbm_pkg::CFG_LAYOUT:     r_layout     <= i_cfg_data[pbm_pkg::LAYOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // classification of the incoming transfer
    always_comb begin
        logic mode_ok;
        logic gray;
        mode_ok = (r_blend_mode <= pbm_pkg::MODE_DARKEN);
        gray    = (r_layout == pbm_pkg::LAYOUT_GRAY);

        n_f_item.a = s_axis_tdata[pbm_pkg::OUT_DATA_W-1:0];
        n_f_item.b = s_axis_tdata[pbm_pkg::IN_DATA_W-1:pbm_pkg::OUT_DATA_W];

        // gray layout blends only in normal mode
        if (!mode_ok || (gray && r_blend_mode != pbm_pkg::MODE_NORMAL))
            n_f_item.cls.colour_mode = pbm_pkg::MODE_PASS;
        else
            n_f_item.cls.colour_mode = r_blend_mode;

        n_f_item.cls.alpha_mode = mode_ok ? pbm_pkg::MODE_NORMAL : pbm_pkg::MODE_PASS;

        case (r_layout)
            pbm_pkg::LAYOUT_GRAY: n_f_item.cls.keep = 4'b0001;
            pbm_pkg::LAYOUT_RGBA: n_f_item.cls.keep = 4'b1111;
            default:              n_f_item.cls.keep = 4'b0111;
        endcase

        n_f_item.cls.op = (r_opacity > pbm_pkg::OP_ONE) ? pbm_pkg::OP_ONE : r_opacity;
    end

    // input register, freed as soon as the queue takes it
    assign s_axis_tready = !r_f_valid || i_q_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_push        = r_f_valid && i_q_ready;
    assign o_item        = r_f_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (accept) begin
            r_f_valid <= 1'b1;
        end else if (o_push) begin
            r_f_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_item <= n_f_item;
        end
    end

endmodule

// ===== hdl/pbm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_queue - short item queue between front and back
// Register-based circular buffer; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
module pbm_queue #(
    parameter int DEPTH = pbm_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pbm_pkg::t_item i_item,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output pbm_pkg::t_item o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    pbm_pkg::t_item  r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push)
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            if (do_pop)
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            if (do_push && !do_pop)
                r_count <= r_count + 1'b1;
            else if (do_pop && !do_push)
                r_count <= r_count - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== hdl/pbm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_lane - arithmetic pipeline for one channel
// Six register stages: operand product, blend numerator over 255, opacity
// weighting, rounded sum over 256, reciprocal multiply for /255, result.
// ----------------------------------------------------------------------------
module pbm_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [pbm_pkg::CH_W-1:0]      i_a,
    input  logic [pbm_pkg::CH_W-1:0]      i_b,
    input  logic [pbm_pkg::MODE_W-1:0]    i_mode,
    input  logic [pbm_pkg::OP_W-1:0]      i_op,
    input  logic                          i_keep,
    output logic [pbm_pkg::CH_W-1:0]      o_res
);

    // stage 1
    logic [15:0]                   r1_prod;
    logic [pbm_pkg::CH_W-1:0]      r1_a;
    logic [pbm_pkg::CH_W-1:0]      r1_v;
    logic [pbm_pkg::MODE_W-1:0]    r1_mode;
    logic                          r1_low;
    logic [pbm_pkg::OP_W-1:0]      r1_op;
    logic                          r1_keep;
    // stage 2
    logic [15:0]                   r2_num;
    logic [pbm_pkg::CH_W-1:0]      r2_a;
    logic [pbm_pkg::OP_W-1:0]      r2_op;
    logic                          r2_keep;
    // stage 3
    logic [23:0]                   r3_pb;
    logic [15:0]                   r3_pa;
    logic                          r3_keep;
    // stage 4
    logic [15:0]                   r4_q;
    logic                          r4_keep;
    // stage 5
    logic [31:0]                   r5_p;
    logic                          r5_keep;
    // stage 6
    logic [pbm_pkg::CH_W-1:0]      r6_res;

    logic [pbm_pkg::CH_W-1:0] op_x;
    logic [pbm_pkg::CH_W-1:0] op_y;
    logic [pbm_pkg::CH_W-1:0] n1_v;
    logic [15:0]              n2_num;
    logic [24:0]              pb_full;
    logic [16:0]              pa_full;
    logic [23:0]              total;
    logic [31:0]              recip;
    logic [8:0]               quo;

    // operand selection for the shared 8x8 product
    always_comb begin
        op_x = i_a;
        op_y = i_b;
        case (i_mode)
            pbm_pkg::MODE_SCREEN: begin
                op_x = ~i_a;
                op_y = ~i_b;
            end
            pbm_pkg::MODE_OVERLAY: begin
                if (i_a[pbm_pkg::CH_W-1]) begin
                    op_x = ~i_a;
                    op_y = ~i_b;
                end
            end
            default: ;
        endcase
    end

    // value scaled by 255 in the linear modes
    always_comb begin
        case (i_mode)
            pbm_pkg::MODE_NORMAL: n1_v = i_b;
            pbm_pkg::MODE_DARKEN: n1_v = (i_a < i_b) ? i_a : i_b;
            default:              n1_v = i_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= op_x * op_y;
            r1_a    <= i_a;
            r1_v    <= n1_v;
            r1_mode <= i_mode;
            r1_low  <= !i_a[pbm_pkg::CH_W-1];
            r1_op   <= i_op;
            r1_keep <= i_keep;
        end
    end

    // blend numerator over 255
    always_comb begin
        logic [16:0] dbl;
        dbl = {r1_prod, 1'b0};
        case (r1_mode)
            pbm_pkg::MODE_MULTIPLY: n2_num = r1_prod;
            pbm_pkg::MODE_SCREEN:   n2_num = pbm_pkg::FULL_SQ - r1_prod;
            pbm_pkg::MODE_OVERLAY:  n2_num = r1_low ? dbl[15:0]
                                                    : pbm_pkg::FULL_SQ - dbl[15:0];
            default:                n2_num = {r1_v, 8'd0} - {8'd0, r1_v};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_num  <= n2_num;
            r2_a    <= r1_a;
            r2_op   <= r1_op;
            r2_keep <= r1_keep;
        end
    end

    // opacity weighting of both terms
    assign pb_full = r2_num * r2_op;
    assign pa_full = r2_a * (pbm_pkg::OP_ONE - r2_op);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pb   <= pb_full[23:0];
            r3_pa   <= pa_full[15:0];
            r3_keep <= r2_keep;
        end
    end

    // first-term times 255, add, round, drop the factor 256
    assign total = {r3_pa, 8'd0} - {8'd0, r3_pa} + r3_pb + pbm_pkg::ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_q    <= total[23:8];
            r4_keep <= r3_keep;
        end
    end

    // floor(q / 255) by reciprocal, exact for 16-bit q
    assign recip = r4_q * pbm_pkg::RECIP_255;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_p    <= recip;
            r5_keep <= r4_keep;
        end
    end

    // saturate and mask unused channels
    assign quo = r5_p[pbm_pkg::RECIP_SH+8:pbm_pkg::RECIP_SH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r5_keep)
                r6_res <= '0;
            else if (quo > pbm_pkg::CH_MAX)
                r6_res <= pbm_pkg::CH_MAX[pbm_pkg::CH_W-1:0];
            else
                r6_res <= quo[pbm_pkg::CH_W-1:0];
        end
    end

    assign o_res = r6_res;

endmodule

// ===== hdl/pbm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_back - blend execution back end
// Pulls classified items from the queue into four channel lanes that advance
// together; the last lane stage is the output register.
// ----------------------------------------------------------------------------
module pbm_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  pbm_pkg::t_item                  i_q_item,
    output logic                            o_q_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pbm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic [pbm_pkg::BACK_STAGES-1:0]           r_vld;
    logic                                      en;
    logic [pbm_pkg::NUM_CH-1:0][pbm_pkg::CH_W-1:0] res;

    // whole pipeline moves unless a finished result is held back
    assign en      = !r_vld[pbm_pkg::BACK_STAGES-1] || m_axis_tready;
    assign o_q_pop = en && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[pbm_pkg::BACK_STAGES-2:0], i_q_valid};
        end
    end

    // channel lanes; alpha uses its own mode
    for (genvar g = 0; g < pbm_pkg::NUM_CH; g++) begin : g_lane
        pbm_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_a    (i_q_item.a[g]),
            .i_b    (i_q_item.b[g]),
            .i_mode ((g == pbm_pkg::NUM_CH - 1) ? i_q_item.cls.alpha_mode
                                                 : i_q_item.cls.colour_mode),
            .i_op   (i_q_item.cls.op),
            .i_keep (i_q_item.cls.keep[g]),
            .o_res  (res[g])
        );
    end

    assign m_axis_tvalid = r_vld[pbm_pkg::BACK_STAGES-1];
    assign m_axis_tdata  = res;

endmodule

// ===== hdl/pixel_blend_modes_with_opacity.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_blend_modes_with_opacity - two-layer pixel blend with opacity
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  two pixels, 64 bits
//   m_axis    out        m_axis_tvalid / m_axis_tready  blended pixel, 32 bits
//   cfg       in         i_cfg_we                       index 2 bits, data 9 bits
//
// One pixel per clock sustained while the output is not stalled. Between an
// input transfer and its output lie the input register, the queue, then six
// lane stages bound by the three multiplies per channel and the reciprocal
// divide by 255.
// Reset is synchronous; it empties the pipeline and restores the registers.
// An output stall freezes the lanes; the queue keeps taking transfers until
// it fills.
// ----------------------------------------------------------------------------
module pixel_blend_modes_with_opacity #(
    parameter int QUEUE_DEPTH = pbm_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pbm_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [pbm_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // first_c0, first_c1, first_c2, first_alpha,
    // second_c0, second_c1, second_c2, second_alpha
    input  logic [pbm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_c0, out_c1, out_c2, out_alpha
    output logic [pbm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           q_pop;
    pbm_pkg::t_item f_item;
    pbm_pkg::t_item q_item;

    pbm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_push        (push),
        .o_item        (f_item),
        .i_q_ready     (q_ready)
    );

    pbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    pbm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== hdl/pbm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_checker - port-level checks for the pixel blend block
// Tracks transfers in flight and checks output behaviour against them.
// ----------------------------------------------------------------------------
module pbm_checker #(
    parameter int QUEUE_DEPTH = pbm_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [pbm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int CAP = 1 + QUEUE_DEPTH + pbm_pkg::BACK_STAGES;
    localparam int PW  = $clog2(CAP + 2);

    logic [PW-1:0] r_pending;
    logic          in_xfer;
    logic          out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // pixels taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_pending <= r_pending + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    // no result without a pixel behind it
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != '0)
        else $error("output valid with no pixel in flight");

    // storage bound of front register, queue and lanes
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PW'(CAP))
        else $error("more pixels in flight than the block can hold");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // a stalled result is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

endmodule

bind pixel_blend_modes_with_opacity pbm_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
